>>> hw/rtl/codel_pkg.sv
// Shared types and constants for the CoDel overload detector.
// No dependencies; imported by codel_ctrl, codel_dp and the top level.
package codel_pkg;

    localparam int CFG_W       = 40;               // target / interval register width
    localparam int CFG_IDX_W   = 1;
    localparam int NOW_W       = 63;
    localparam int DEADLINE_W  = 64;
    localparam int TWICE_W     = CFG_W + 1;        // twice the effective target
    localparam int LOAD_W      = 7;
    localparam int QUOT_STEPS  = 7;                // quotient bits, load is below 128
    localparam int STEP_W      = $clog2(QUOT_STEPS);
    localparam int NUM_W       = TWICE_W + LOAD_W; // min * 100 when min < twice

    localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 1'b1;

    localparam logic [CFG_W-1:0]  TARGET_RESET   = 40'd5000000;
    localparam logic [CFG_W-1:0]  INTERVAL_RESET = 40'd100000000;
    localparam logic [LOAD_W-1:0] LOAD_SAT       = 7'd100;

    // controller -> datapath commands
    typedef struct packed {
        logic capture;   // latch input transaction
        logic update;    // interval / minimum / drop update
        logic prep;      // set up load quotient
        logic step;      // one quotient bit
    } codel_cmd_t;

endpackage

>>> hw/rtl/codel_ctrl.sv
// Controller FSM for the CoDel overload detector: handshakes and sequencing.
// Depends on codel_pkg; drives codel_dp through codel_cmd_t.
module codel_ctrl
    import codel_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output codel_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_PREP,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic                s_ready_reg, s_ready_next;
    logic                m_valid_reg, m_valid_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;

    always_comb begin
        state_next   = state_reg;
        s_ready_next = s_ready_reg;
        m_valid_next = m_valid_reg;
        cnt_next     = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    state_next   = ST_UPDATE;
                    s_ready_next = 1'b0;
                end
            end
            ST_UPDATE: begin
                state_next = ST_PREP;
            end
            ST_PREP: begin
                state_next = ST_DIVIDE;
                cnt_next   = STEP_W'(QUOT_STEPS - 1);
            end
            ST_DIVIDE: begin
                if (cnt_reg == '0) begin
                    state_next   = ST_DONE;
                    m_valid_next = 1'b1;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b0;
                    s_ready_next = 1'b1;
                end
            end
            default: begin
                state_next   = ST_IDLE;
                s_ready_next = 1'b1;
                m_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    assign s_ready     = s_ready_reg;
    assign m_valid     = m_valid_reg;
    assign cmd.capture = (state_reg == ST_IDLE) && s_valid && s_ready_reg;
    assign cmd.update  = (state_reg == ST_UPDATE);
    assign cmd.prep    = (state_reg == ST_PREP);
    assign cmd.step    = (state_reg == ST_DIVIDE);

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready_reg == (state_reg == ST_IDLE))
        else $error("s_ready out of step with IDLE state");

    a_valid_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg == (state_reg == ST_DONE))
        else $error("m_valid out of step with DONE state");

    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.prep |=> cmd.step ##(QUOT_STEPS - 1) cmd.step ##1 m_valid_reg)
        else $error("quotient loop length wrong");

endmodule

>>> hw/rtl/codel_dp.sv
// Datapath for the CoDel overload detector: config registers, interval state,
// drop decision and the bit-serial load quotient. Depends on codel_pkg.
module codel_dp
    import codel_pkg::*;
#(
    parameter int DELAY_BITS = 48
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  codel_cmd_t            cmd,
    input  logic [DELAY_BITS-1:0] s_request_delay,
    input  logic [NOW_W-1:0]      s_now_ns,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    output logic                  m_drop,
    output logic [LOAD_W-1:0]     m_load_percent
);

    localparam int CMP_W = (DELAY_BITS > TWICE_W) ? DELAY_BITS : TWICE_W;

    logic [CFG_W-1:0]      target_reg, interval_reg;
    logic [DELAY_BITS-1:0] delay_reg;
    logic [NOW_W-1:0]      now_reg;
    logic [DELAY_BITS-1:0] min_delay_reg, min_delay_next;
    logic [DEADLINE_W-1:0] deadline_reg, deadline_next;
    logic                  pending_reg, pending_next;
    logic                  overloaded_reg, overloaded_next;
    logic                  drop_reg, drop_next;
    logic [TWICE_W-1:0]    twice_reg;
    logic                  sat_reg, sat_next;
    logic [NUM_W-1:0]      rem_reg, rem_next;
    logic [NUM_W-1:0]      div_reg, div_next;
    logic [LOAD_W-1:0]     quot_reg, quot_next;

    logic [CFG_W-1:0]      eff_target;
    logic [TWICE_W-1:0]    twice;
    logic                  rollover;
    logic [CMP_W-1:0]      delay_ext, min_ext, twice_ext, target_ext, twice_reg_ext;
    logic [TWICE_W-1:0]    min_low;
    logic [NUM_W-1:0]      min_wide;

    assign eff_target    = (target_reg < interval_reg) ? target_reg : interval_reg;
    assign twice         = {eff_target, 1'b0};
    assign delay_ext     = CMP_W'(delay_reg);
    assign min_ext       = CMP_W'(min_delay_reg);
    assign twice_ext     = CMP_W'(twice);
    assign twice_reg_ext = CMP_W'(twice_reg);
    assign target_ext    = CMP_W'(eff_target);
    assign rollover      = (DEADLINE_W'(now_reg) > deadline_reg) && !pending_reg;
    // below twice the target, the minimum fits the twice width
    assign min_low       = min_ext[TWICE_W-1:0];
    assign min_wide      = NUM_W'(min_low);

    always_comb begin
        min_delay_next  = min_delay_reg;
        deadline_next   = deadline_reg;
        pending_next    = pending_reg;
        overloaded_next = overloaded_reg;
        drop_next       = drop_reg;
        sat_next        = sat_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        quot_next       = quot_reg;

        if (cmd.update) begin
            if (rollover) begin
                deadline_next   = DEADLINE_W'(now_reg) + DEADLINE_W'(interval_reg);
                overloaded_next = min_ext > target_ext;
            end
            if (pending_reg || rollover) begin
                pending_next   = 1'b0;
                min_delay_next = delay_reg;
                drop_next      = 1'b0;
            end else begin
                if (delay_reg < min_delay_reg) begin
                    min_delay_next = delay_reg;
                end
                drop_next = overloaded_reg && (delay_ext > twice_ext);
            end
        end

        if (cmd.prep) begin
            sat_next  = (twice_reg == '0) || (min_ext >= twice_reg_ext);
            // min * 100 = min*64 + min*32 + min*4
            rem_next  = (min_wide << 6) + (min_wide << 5) + (min_wide << 2);
            div_next  = NUM_W'(twice_reg) << (QUOT_STEPS - 1);
            quot_next = '0;
        end

        if (cmd.step) begin
            if (rem_reg >= div_reg) begin
                rem_next  = rem_reg - div_reg;
                quot_next = {quot_reg[LOAD_W-2:0], 1'b1};
            end else begin
                quot_next = {quot_reg[LOAD_W-2:0], 1'b0};
            end
            div_next = div_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg     <= TARGET_RESET;
            interval_reg   <= INTERVAL_RESET;
            min_delay_reg  <= '0;
            deadline_reg   <= '0;
            pending_reg    <= 1'b1;
            overloaded_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_TARGET) begin
                    target_reg <= cfg_wdata;
                end
                if (cfg_index == REG_INTERVAL) begin
                    interval_reg <= cfg_wdata;
                end
            end
            min_delay_reg  <= min_delay_next;
            deadline_reg   <= deadline_next;
            pending_reg    <= pending_next;
            overloaded_reg <= overloaded_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            delay_reg <= s_request_delay;
            now_reg   <= s_now_ns;
        end
        if (cmd.update) begin
            twice_reg <= twice;
        end
        drop_reg <= drop_next;
        sat_reg  <= sat_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        quot_reg <= quot_next;
    end

    assign m_drop         = drop_reg;
    assign m_load_percent = sat_reg ? LOAD_SAT : quot_reg;

    a_pending_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |=> !pending_reg)
        else $error("reset-pending flag not cleared by update");

    a_first_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update && (pending_reg || rollover) |=> !drop_reg)
        else $error("seeding request marked for drop");

    a_quot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step && !sat_reg |-> quot_reg < LOAD_SAT)
        else $error("load quotient out of range");

endmodule

>>> hw/rtl/codel_overload_slougher.sv
// Top level of the CoDel overload detector.
// Depends on codel_pkg, codel_ctrl and codel_dp.
//
// Usage:
//   Input channel s_*: one transaction per request, carrying its queueing
//   delay and the current time in ns. Result channel m_*: one transaction per
//   request, carrying the drop decision and the load percentage (0..100).
//   Config port: cfg_we with cfg_index (0 target, 1 interval) and cfg_wdata,
//   written while cfg_we is high; write only while no request is in flight.
// Sequencing:
//   after the input transaction the controller passes through UPDATE, PREP
//   and DIVIDE, where the bit-serial load quotient yields one bit per cycle,
//   and raises m_valid in DONE; s_ready returns in the cycle after the
//   result transaction. One request is in flight at a time.
// Reset and stall:
//   aresetn (synchronous, active low) restores default target and interval,
//   clears the minimum and deadline and arms the seeding of the next request.
//   A stalled receiver holds the result stable and keeps s_ready low.
module codel_overload_slougher
    import codel_pkg::*;
#(
    parameter int DELAY_BITS = 48
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DELAY_BITS-1:0] s_request_delay,
    input  logic [NOW_W-1:0]      s_now_ns,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_drop,
    output logic [LOAD_W-1:0]     m_load_percent,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    codel_cmd_t cmd;

    codel_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    codel_dp #(
        .DELAY_BITS (DELAY_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .s_request_delay (s_request_delay),
        .s_now_ns        (s_now_ns),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .m_drop          (m_drop),
        .m_load_percent  (m_load_percent)
    );

endmodule
